FILE: rtl/core/spq_pkg.sv
// shared types and codes for the stable priority queue
package spq_pkg;

    localparam int STATUS_BITS = 2;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } spq_status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } spq_op_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } spq_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } spq_cmd_t;

endpackage

FILE: rtl/core/spq_req_if.sv
// request channel: insert or remove beat
interface spq_req_if #(
    parameter int URGENCY_BITS = 8,
    parameter int PAYLOAD_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [URGENCY_BITS-1:0] urgency;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, output opcode, output urgency, output payload, input ready);
    modport sink   (input valid, input opcode, input urgency, input payload, output ready);
endinterface

FILE: rtl/core/spq_rsp_if.sv
// response channel: status, removed entry and occupancy
interface spq_rsp_if #(
    parameter int URGENCY_BITS = 8,
    parameter int PAYLOAD_BITS = 16,
    parameter int COUNT_BITS   = 5
);
    logic                               valid;
    logic                               ready;
    logic [spq_pkg::STATUS_BITS-1:0]    status;
    logic [URGENCY_BITS-1:0]            out_urgency;
    logic [PAYLOAD_BITS-1:0]            out_payload;
    logic [COUNT_BITS-1:0]              occupancy;

    modport source (output valid, output status, output out_urgency, output out_payload,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_urgency, input out_payload,
                    input occupancy, output ready);
endinterface

FILE: rtl/core/spq_ctrl.sv
// controller: accept, execute and response handshake sequencing
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output spq_pkg::spq_cmd_t cmd
);
    import spq_pkg::*;

    spq_state_t state_reg;
    spq_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                // result register must be free or draining this cycle
                cmd.exec = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
                cmd      = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_exec_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    a_load_exec_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.exec))
        else $error("load and execute in the same cycle");

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("execute did not raise result valid");

    a_load_then_exec_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_EXEC))
        else $error("accepted beat not followed by execute state");

endmodule

FILE: rtl/core/spq_dp.sv
// datapath: sorted slot row, occupancy counter and result register
module spq_dp #(
    parameter int DEPTH        = 16,
    parameter int URGENCY_BITS = 8,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  spq_pkg::spq_cmd_t                    cmd,
    input  logic                                 opcode,
    input  logic [URGENCY_BITS-1:0]              urgency,
    input  logic [PAYLOAD_BITS-1:0]              payload,
    output logic [spq_pkg::STATUS_BITS-1:0]      status,
    output logic [URGENCY_BITS-1:0]              out_urgency,
    output logic [PAYLOAD_BITS-1:0]              out_payload,
    output logic [$clog2(DEPTH+1)-1:0]           occupancy
);
    import spq_pkg::*;

    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    // latched request
    logic                    op_reg;
    logic [URGENCY_BITS-1:0] urg_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    logic [URGENCY_BITS-1:0] slot_u_reg  [DEPTH];
    logic [URGENCY_BITS-1:0] slot_u_next [DEPTH];
    logic [PAYLOAD_BITS-1:0] slot_p_reg  [DEPTH];
    logic [PAYLOAD_BITS-1:0] slot_p_next [DEPTH];
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;

    spq_status_t             status_reg;
    spq_status_t             status_next;
    logic [URGENCY_BITS-1:0] out_u_reg;
    logic [URGENCY_BITS-1:0] out_u_next;
    logic [PAYLOAD_BITS-1:0] out_p_reg;
    logic [PAYLOAD_BITS-1:0] out_p_next;
    logic [COUNT_BITS-1:0]   occ_reg;

    logic is_remove;
    logic full;
    logic empty;
    logic do_ins;
    logic do_rem;

    // per slot: stored entry stays ahead of the new one
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] prev_ge;

    assign is_remove = (op_reg == OP_REMOVE);
    assign full      = (count_reg == COUNT_BITS'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_ins    = cmd.exec && !is_remove && !full;
    assign do_rem    = cmd.exec && is_remove && !empty;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [URGENCY_BITS-1:0] above_u;
        logic [PAYLOAD_BITS-1:0] above_p;
        logic [URGENCY_BITS-1:0] below_u;
        logic [PAYLOAD_BITS-1:0] below_p;

        assign ge[g] = (COUNT_BITS'(g) < count_reg) && (slot_u_reg[g] >= urg_reg);

        if (g == 0)
        begin : g_head
            assign prev_ge[g] = 1'b1;
            assign above_u    = urg_reg;
            assign above_p    = pay_reg;
        end
        else
        begin : g_body
            assign prev_ge[g] = ge[g-1];
            assign above_u    = slot_u_reg[g-1];
            assign above_p    = slot_p_reg[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign below_u = slot_u_reg[g];
            assign below_p = slot_p_reg[g];
        end
        else
        begin : g_inner
            assign below_u = slot_u_reg[g+1];
            assign below_p = slot_p_reg[g+1];
        end

        always_comb
        begin
            if (do_rem)
            begin
                slot_u_next[g] = below_u;
                slot_p_next[g] = below_p;
            end
            else if (ge[g])
            begin
                slot_u_next[g] = slot_u_reg[g];
                slot_p_next[g] = slot_p_reg[g];
            end
            else if (prev_ge[g])
            begin
                // insertion point: first slot not ahead of the new entry
                slot_u_next[g] = urg_reg;
                slot_p_next[g] = pay_reg;
            end
            else
            begin
                slot_u_next[g] = above_u;
                slot_p_next[g] = above_p;
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_OK;
        out_u_next  = '0;
        out_p_next  = '0;
        if (is_remove)
        begin
            if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                out_u_next = slot_u_reg[0];
                out_p_next = slot_p_reg[0];
                count_next = count_reg - COUNT_BITS'(1);
            end
        end
        else
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            urg_reg <= urgency;
            pay_reg <= payload;
        end
        if (do_ins || do_rem)
        begin
            slot_u_reg <= slot_u_next;
            slot_p_reg <= slot_p_next;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            out_u_reg  <= out_u_next;
            out_p_reg  <= out_p_next;
            occ_reg    <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status      = status_reg;
    assign out_urgency = out_u_reg;
    assign out_payload = out_p_reg;
    assign occupancy   = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(DEPTH))
        else $error("occupancy above depth");

    a_remove_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        do_rem |=> (count_reg == $past(count_reg) - COUNT_BITS'(1)))
        else $error("remove did not decrement occupancy");

    a_insert_increments: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> (count_reg == $past(count_reg) + COUNT_BITS'(1)))
        else $error("insert did not increment occupancy");

    a_ge_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> ((ge & ~prev_ge) == '0))
        else $error("slot row out of order");

endmodule

FILE: rtl/core/stable_priority_queue_top.sv
// Stable priority queue of DEPTH entries kept sorted by urgency, most urgent at the head and
// equal urgencies in arrival order. Each request beat (insert or remove) is first captured; an
// execute state then compares every slot against the new urgency in parallel and shifts the
// slot row by one place. The next request beat is taken the cycle after execution, so the
// capture/execute controller takes no new beat while one is still executing. The response sits
// in an output register, so a new request is
// accepted while an earlier response still waits; execution waits only when that register is
// still full. Remove on an empty queue returns status empty, insert on a full queue returns
// status full and drops the entry; removed fields read zero on every other response. Stored
// slots have no reset and only slots below the occupancy are ever used.
module stable_priority_queue_top #(
    parameter int DEPTH        = 16,
    parameter int URGENCY_BITS = 8,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    spq_dp #(
        .DEPTH        (DEPTH),
        .URGENCY_BITS (URGENCY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (req.opcode),
        .urgency     (req.urgency),
        .payload     (req.payload),
        .status      (rsp.status),
        .out_urgency (rsp.out_urgency),
        .out_payload (rsp.out_payload),
        .occupancy   (rsp.occupancy)
    );

endmodule
